@@ src/rom_prefetch_buffer_macros.svh @@
// ----------------------------------------------------------------------------
// rom_prefetch_buffer_macros - assertion helpers
// Shared concurrent assertion macros, clocked on clk_i, off while in reset.
// ----------------------------------------------------------------------------
`ifndef ROM_PREFETCH_BUFFER_MACROS_SVH
`define ROM_PREFETCH_BUFFER_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define RPB_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Antecedent in this cycle implies consequent in the same cycle.
`define RPB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ src/rpb_pkg.sv @@
// ----------------------------------------------------------------------------
// rpb_pkg - ROM prefetch buffer package
// Widths, register indexes and the sequential fetch cost table.
// ----------------------------------------------------------------------------
package rpb_pkg;

  localparam int AddrW       = 32;
  localparam int CycW        = 5;
  localparam int CountW      = 4;
  localparam int CostW       = 5;   // largest fetch cost is 18
  localparam int BufferSlots = 8;
  localparam int SlotW       = $clog2(BufferSlots);
  localparam int CapThumb    = (BufferSlots < 8) ? BufferSlots : 8;
  localparam int CapArm      = (BufferSlots < 4) ? BufferSlots : 4;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgSramWait      = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgWs0Nonseq     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgWs0Seq        = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgWs1Nonseq     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgWs1Seq        = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgWs2Nonseq     = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgWs2Seq        = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgPrefetchEnable = 3'd7;

  localparam logic [AddrW-1:0] RomLo = 32'h0800_0000;
  localparam logic [AddrW-1:0] RomHi = 32'h0EFF_FFFF;

  // Address regions, bits 31..24
  localparam logic [7:0] RegEwram  = 8'h02;
  localparam logic [7:0] RegPal    = 8'h05;
  localparam logic [7:0] RegVram   = 8'h06;
  localparam logic [7:0] RegWs0Lo  = 8'h08;
  localparam logic [7:0] RegWs0Hi  = 8'h09;
  localparam logic [7:0] RegWs1Lo  = 8'h0A;
  localparam logic [7:0] RegWs1Hi  = 8'h0B;
  localparam logic [7:0] RegWs2Lo  = 8'h0C;
  localparam logic [7:0] RegWs2Hi  = 8'h0D;
  localparam logic [7:0] RegSram   = 8'h0E;

  typedef struct packed {
    logic [1:0] sram_wait;
    logic       ws0_seq;
    logic       ws1_seq;
    logic       ws2_seq;
    logic       prefetch_enable;
  } cfg_t;

  function automatic logic in_rom(input logic [AddrW-1:0] a);
    return (a >= RomLo) && (a <= RomHi);
  endfunction

  // SRAM waits 4,3,2,8 plus the access itself
  function automatic logic [CostW-1:0] sram_cost(input logic [1:0] sel);
    logic [CostW-1:0] c;
    case (sel)
      2'd0:    c = CostW'(5);
      2'd1:    c = CostW'(4);
      2'd2:    c = CostW'(3);
      default: c = CostW'(9);
    endcase
    return c;
  endfunction

  function automatic logic [CostW-1:0] seq_cost(input logic [7:0] region,
                                                 input logic       thumb,
                                                 input cfg_t       cfg);
    logic [CostW-1:0] s16;
    logic [CostW-1:0] c;
    logic             wide;
    s16  = CostW'(1);
    c    = CostW'(1);
    wide = 1'b0;
    case (region)
      RegWs0Lo, RegWs0Hi: begin
        s16  = cfg.ws0_seq ? CostW'(2) : CostW'(3);
        wide = 1'b1;
      end
      RegWs1Lo, RegWs1Hi: begin
        s16  = cfg.ws1_seq ? CostW'(2) : CostW'(5);
        wide = 1'b1;
      end
      RegWs2Lo, RegWs2Hi: begin
        s16  = cfg.ws2_seq ? CostW'(2) : CostW'(9);
        wide = 1'b1;
      end
      RegSram:          c = sram_cost(cfg.sram_wait);
      RegEwram:         c = thumb ? CostW'(3) : CostW'(6);
      RegPal, RegVram:  c = thumb ? CostW'(1) : CostW'(2);
      default:          c = CostW'(1);
    endcase
    if (wide) begin
      c = thumb ? s16 : {s16[CostW-2:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [SlotW-1:0] slot_inc(input logic [SlotW-1:0] s);
    return (s == SlotW'(BufferSlots - 1)) ? '0 : s + SlotW'(1);
  endfunction

endpackage

@@ src/rpb_if.sv @@
// ----------------------------------------------------------------------------
// rpb_if - ROM prefetch buffer channels
// Access request, charge response and register write channels.
// ----------------------------------------------------------------------------
interface rpb_req_if import rpb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [AddrW-1:0] access_address;
  logic [CycW-1:0]  base_cycles;
  logic [AddrW-1:0] program_counter;
  logic             thumb_mode;

  modport source (output valid, access_address, base_cycles, program_counter,
                  thumb_mode, input ready);
  modport sink   (input valid, access_address, base_cycles, program_counter,
                  thumb_mode, output ready);
endinterface

interface rpb_rsp_if import rpb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CycW-1:0]   charged_cycles;
  logic              served_from_buffer;
  logic [CountW-1:0] buffered_count;

  modport source (output valid, charged_cycles, served_from_buffer, buffered_count,
                  input ready);
  modport sink   (input valid, charged_cycles, served_from_buffer, buffered_count,
                  output ready);
endinterface

interface rpb_cfg_if import rpb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/rom_prefetch_buffer.sv @@
// ----------------------------------------------------------------------------
// rom_prefetch_buffer - cartridge ROM prefetch cycle accounting
// Charges each bus access the cycles it really costs with prefetch in play.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  : one bus access per request (address, base cost, PC, thumb flag);
//            an idle cycle is sent as address 0 costing 1.
//   rsp_o  : one response per request: charged cycles, buffer hit flag and
//            the number of completed prefetched entries left.
//   cfg_i  : register writes (index 0..7), always ready; write only while idle.
// Response: registered, valid in the cycle after the request is taken.
// Throughput: one request per cycle while rsp_o is not stalled. The whole update (hit check, fetch start,
//   countdown) is one pass of logic into the state and response registers;
//   the head entry of the ring comes out of a small RAM whose read address
//   follows the next read slot, so its data is ready for the following request.
// Stall: the response register holds while rsp_o.ready is low; req_i.ready is
//   low only while a response waits and the receiver is stalled.
// Reset: config, response valid, ring pointers, fill count and in-flight fetch clear; ring
//   RAM contents are not cleared (entries are only read after being written).
// ----------------------------------------------------------------------------
`include "rom_prefetch_buffer_macros.svh"

module rom_prefetch_buffer import rpb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  rpb_req_if.sink   req_i,
  rpb_rsp_if.source rsp_o,
  rpb_cfg_if.sink   cfg_i
);

  // Configuration
  cfg_t cfg_q;

  // Prefetch state
  logic              active_q, active_d;
  logic [CostW-1:0]  cd_q, cd_d;
  logic [CountW-1:0] count_q, count_d;
  logic [SlotW-1:0]  rs_q, rs_d;
  logic [SlotW-1:0]  ws_q, ws_d;
  logic [AddrW-1:0]  newest_q, newest_d;
  logic [AddrW-1:0]  prev_q, prev_d;

  // Response register
  logic              out_valid_q;
  logic [CycW-1:0]   charged_q;
  logic              served_q;
  logic [CountW-1:0] buffered_q;

  // Ring RAM and its read-during-write bypass
  logic             ram_we;
  logic [SlotW-1:0] ram_raddr;
  logic [AddrW-1:0] ram_rdata;
  logic             byp_q;
  logic [AddrW-1:0] byp_data_q;
  logic [AddrW-1:0] head_addr;

  // Datapath
  logic              accept;
  logic [AddrW-1:0]  addr;
  logic [AddrW-1:0]  pc;
  logic              thumb;
  logic              rom_a;
  logic              rom_pc;
  logic [CountW-1:0] cap;
  logic [AddrW-1:0]  next_addr;
  logic [CycW-1:0]   cyc;
  logic              served;
  logic              do_adv;

  // Ring bookkeeping check
  logic [SlotW:0]   ring_sum;
  logic [SlotW-1:0] ring_exp;

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign cfg_i.ready = 1'b1;

  assign addr   = req_i.access_address;
  assign pc     = req_i.program_counter;
  assign thumb  = req_i.thumb_mode;
  assign rom_a  = in_rom(addr);
  assign rom_pc = in_rom(pc);
  assign cap    = thumb ? CountW'(CapThumb) : CountW'(CapArm);

  // Next fetch continues from the newest entry, or from the PC when empty
  assign next_addr = ((count_q != '0) ? newest_q : pc)
                   + (thumb ? AddrW'(2) : AddrW'(4));

  assign head_addr = byp_q ? byp_data_q : ram_rdata;

  always_comb begin
    active_d = active_q;
    cd_d     = cd_q;
    count_d  = count_q;
    rs_d     = rs_q;
    ws_d     = ws_q;
    newest_d = newest_q;
    prev_d   = prev_q;
    cyc      = req_i.base_cycles;
    served   = 1'b0;
    ram_we   = 1'b0;
    do_adv   = 1'b1;

    if (!cfg_q.prefetch_enable) begin
      // pass-through; in-flight fetch still counts down
    end else if (active_q && addr == newest_q) begin
      // hit on the fetch still in flight: wait out its remaining cycles
      cyc      = CycW'(cd_q);
      active_d = 1'b0;
      cd_d     = '0;
      prev_d   = addr;
      served   = 1'b1;
      do_adv   = 1'b0;
    end else begin
      if (active_q) begin
        if (rom_a) begin
          active_d = 1'b0;   // ROM bus taken by the access, fetch dropped
        end
      end else if (count_q < cap && rom_pc && !rom_a && pc == prev_q) begin
        newest_d = next_addr;
        active_d = 1'b1;
        ram_we   = 1'b1;
        cd_d     = seq_cost(next_addr[AddrW-1:AddrW-8], thumb, cfg_q);
      end
      if (rom_a) begin
        prev_d = addr;
      end
      if (count_q != '0 && addr == pc) begin
        if (addr == head_addr) begin
          cyc     = CycW'(1);
          served  = 1'b1;
          count_d = count_q - CountW'(1);
          rs_d    = slot_inc(rs_q);
        end else begin
          // opcode miss: flush
          active_d = 1'b0;
          count_d  = '0;
          rs_d     = '0;
          ws_d     = '0;
        end
      end
    end

    // countdown of the in-flight fetch by the cycles this access takes
    if (do_adv && active_d) begin
      if (CostW'(cyc) >= cd_d) begin
        cd_d     = '0;
        count_d  = count_d + CountW'(1);
        ws_d     = slot_inc(ws_d);
        active_d = 1'b0;
      end else begin
        cd_d = cd_d - CostW'(cyc);
      end
    end
  end

  // Read address tracks the read slot the next request will see
  assign ram_raddr = accept ? rs_d : rs_q;

  rpb_ram #(
    .WIDTH (AddrW),
    .DEPTH (BufferSlots)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (accept && ram_we),
    .waddr_i (ws_q),
    .wdata_i (next_addr),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= accept && ram_we && (ws_q == ram_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= next_addr;
  end

  // Configuration registers; nonsequential selects play no part in fetch
  // timing and are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgSramWait:       cfg_q.sram_wait       <= cfg_i.data;
        CfgWs0Seq:         cfg_q.ws0_seq         <= cfg_i.data[0];
        CfgWs1Seq:         cfg_q.ws1_seq         <= cfg_i.data[0];
        CfgWs2Seq:         cfg_q.ws2_seq         <= cfg_i.data[0];
        CfgPrefetchEnable: cfg_q.prefetch_enable <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // State update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cd_q     <= '0;
      count_q  <= '0;
      rs_q     <= '0;
      ws_q     <= '0;
      prev_q   <= '0;
    end else if (accept) begin
      active_q <= active_d;
      cd_q     <= cd_d;
      count_q  <= count_d;
      rs_q     <= rs_d;
      ws_q     <= ws_d;
      prev_q   <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      newest_q <= newest_d;
    end
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      charged_q  <= cyc;
      served_q   <= served;
      buffered_q <= count_d;
    end
  end

  assign rsp_o.valid              = out_valid_q;
  assign rsp_o.charged_cycles     = charged_q;
  assign rsp_o.served_from_buffer = served_q;
  assign rsp_o.buffered_count     = buffered_q;

  // Write slot runs ahead of the read slot by the fill count
  assign ring_sum = {1'b0, rs_q} + (SlotW+1)'(count_q);
  assign ring_exp = (ring_sum >= (SlotW+1)'(BufferSlots))
                  ? SlotW'(ring_sum - (SlotW+1)'(BufferSlots))
                  : SlotW'(ring_sum);

  `RPB_ASSERT(a_count_cap, count_q <= CountW'(CapThumb), "fill count above capacity")
  `RPB_ASSERT_IMPL(a_active_cd, active_q, cd_q != '0, "in-flight fetch with zero countdown")
  `RPB_ASSERT(a_ring_ptrs, ws_q == ring_exp, "ring pointers disagree with fill count")

endmodule

@@ src/rpb_ram.sv @@
// ----------------------------------------------------------------------------
// rpb_ram - generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rpb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
